// ===== sv/scalar_kalman_filter_defines.svh =====
// assertion macros for the scalar kalman filter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

`ifndef SYNTH

`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`define SKF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant failed");

`else

`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`define SKF_ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

// ===== sv/skf_pkg.sv =====
// shared types and constants for the scalar kalman filter
// no dependencies; imported by skf_ctrl, skf_dp and the top level
package skf_pkg;

    // fixed-point layout
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int GAIN_W    = FRAC_W + 1;
    localparam int DIV_STEPS = FRAC_W + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int IDX_W     = 2;

    localparam logic [GAIN_W-1:0] ONE_GAIN = GAIN_W'(1) << FRAC_W;

    // register reset values
    localparam logic [DATA_W-1:0] RST_PROCESS_VAR = DATA_W'(65536);
    localparam logic [DATA_W-1:0] RST_MEAS_VAR    = DATA_W'(655360);
    localparam logic [DATA_W-1:0] RST_INIT_EST    = DATA_W'(0);
    localparam logic [DATA_W-1:0] RST_INIT_ERR    = DATA_W'(65536);

    // configuration register map
    typedef enum logic [IDX_W-1:0] {
        REG_PROCESS_VAR = 2'd0,
        REG_MEAS_VAR    = 2'd1,
        REG_INIT_EST    = 2'd2,
        REG_INIT_ERR    = 2'd3
    } cfg_idx_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_ERR,
        ST_DONE
    } state_t;

    // datapath commands
    typedef struct packed {
        logic load_in;
        logic pred;
        logic div_first;
        logic div_step;
        logic mul_est;
        logic mul_err;
        logic commit;
    } dp_cmd_t;

endpackage

// ===== sv/skf_dp.sv =====
// datapath: config registers, filter state, bit-serial gain divider,
// shared multiplier and result registers; depends on skf_pkg
module skf_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  skf_pkg::dp_cmd_t               cmd,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [skf_pkg::IDX_W-1:0]      cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]     cfg_data,
    input  logic signed [skf_pkg::DATA_W-1:0] measurement,
    output logic signed [skf_pkg::DATA_W-1:0] new_estimate,
    output logic [skf_pkg::DATA_W-1:0]     new_error,
    output logic [skf_pkg::GAIN_W-1:0]     gain
);
    import skf_pkg::*;

    localparam int DIFF_W = DATA_W + 1;
    localparam int MA_W   = GAIN_W + 1;
    localparam int MB_W   = DATA_W + 2;
    localparam int PROD_W = MA_W + MB_W;
    localparam int REM_W  = DATA_W + 2;
    localparam int SHR_W  = PROD_W - FRAC_W;
    localparam int NSUM_W = SHR_W + 1;

    // configuration registers
    logic [DATA_W-1:0]        pv_reg;
    logic [DATA_W-1:0]        mv_reg;
    logic [DATA_W-1:0]        init_est_reg;
    logic [DATA_W-1:0]        init_err_reg;

    // filter state
    logic signed [DATA_W-1:0] est_reg;
    logic signed [DATA_W-1:0] est_next;
    logic [DATA_W-1:0]        err_reg;
    logic [DATA_W-1:0]        err_next;

    // working registers
    logic signed [DATA_W-1:0] meas_reg;
    logic [DATA_W-1:0]        p_reg;
    logic [DATA_W:0]          d_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [GAIN_W-1:0]        q_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] nest_reg;

    // result registers
    logic signed [DATA_W-1:0] out_est_reg;
    logic [DATA_W-1:0]        out_err_reg;
    logic [GAIN_W-1:0]        out_gain_reg;

    logic [DATA_W:0]          p_sum;
    logic [DATA_W-1:0]        p_sat;
    logic [REM_W-1:0]         rem_sh;
    logic                     rem_ge;
    logic [GAIN_W-1:0]        gain_w;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [NSUM_W-1:0] nest_sum;
    logic signed [DATA_W-1:0] nest_sat;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg       <= RST_PROCESS_VAR;
            mv_reg       <= RST_MEAS_VAR;
            init_est_reg <= RST_INIT_EST;
            init_err_reg <= RST_INIT_ERR;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_PROCESS_VAR: pv_reg       <= cfg_data;
                REG_MEAS_VAR:    mv_reg       <= cfg_data;
                REG_INIT_EST:    init_est_reg <= cfg_data;
                REG_INIT_ERR:    init_err_reg <= cfg_data;
                default:         pv_reg       <= pv_reg;
            endcase
        end
    end

    // state update: reload on initial writes, step result on commit
    always_comb
    begin
        est_next = est_reg;
        err_next = err_reg;
        if (cfg_valid && cfg_idx_t'(cfg_index) == REG_INIT_EST)
        begin
            est_next = cfg_data;
            err_next = init_err_reg;
        end
        else if (cfg_valid && cfg_idx_t'(cfg_index) == REG_INIT_ERR)
        begin
            est_next = init_est_reg;
            err_next = cfg_data;
        end
        else if (cmd.commit)
        begin
            est_next = nest_reg;
            err_next = prod_reg[FRAC_W +: DATA_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= RST_INIT_EST;
            err_reg <= RST_INIT_ERR;
        end
        else
        begin
            est_reg <= est_next;
            err_reg <= err_next;
        end
    end

    // predicted error, saturated
    assign p_sum = {1'b0, err_reg} + {1'b0, pv_reg};
    assign p_sat = p_sum[DATA_W] ? {DATA_W{1'b1}} : p_sum[DATA_W-1:0];

    // one restoring divider step; the first step does not shift
    assign rem_sh = cmd.div_first ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign rem_ge = rem_sh >= {1'b0, d_reg};

    // zero denominator gives zero gain
    assign gain_w = (d_reg == '0) ? '0 : q_reg;

    // shared multiplier operands
    always_comb
    begin
        if (cmd.mul_err)
        begin
            mul_a = signed'({1'b0, ONE_GAIN - gain_w});
            mul_b = signed'({2'b00, p_reg});
        end
        else
        begin
            mul_a = signed'({1'b0, gain_w});
            mul_b = MB_W'(diff_reg);
        end
    end

    assign mul_p = mul_a * mul_b;

    // estimate update with floor shift and signed saturation
    assign nest_sum = NSUM_W'(est_reg) + NSUM_W'(signed'(prod_reg[PROD_W-1:FRAC_W]));

    always_comb
    begin
        if (nest_sum[NSUM_W-1:DATA_W-1] == '0 || nest_sum[NSUM_W-1:DATA_W-1] == '1)
            nest_sat = nest_sum[DATA_W-1:0];
        else if (nest_sum[NSUM_W-1])
            nest_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            nest_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end

    // working registers, sequenced by the controller
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            meas_reg <= measurement;
            p_reg    <= p_sat;
        end
        if (cmd.pred)
        begin
            d_reg    <= {1'b0, p_reg} + {1'b0, mv_reg};
            rem_reg  <= {2'b00, p_reg};
            q_reg    <= '0;
            diff_reg <= DIFF_W'(meas_reg) - DIFF_W'(est_reg);
        end
        if (cmd.div_first || cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sh - {1'b0, d_reg} : rem_sh;
            q_reg   <= {q_reg[GAIN_W-2:0], rem_ge};
        end
        if (cmd.mul_est || cmd.mul_err)
            prod_reg <= mul_p;
        if (cmd.mul_err)
            nest_reg <= nest_sat;
        if (cmd.commit)
        begin
            out_est_reg  <= nest_reg;
            out_err_reg  <= prod_reg[FRAC_W +: DATA_W];
            out_gain_reg <= gain_w;
        end
    end

    assign new_estimate = out_est_reg;
    assign new_error    = out_err_reg;
    assign gain         = out_gain_reg;

endmodule

// ===== sv/skf_ctrl.sv =====
// controller: sequences one item through predict, divide, two multiplies
// and commit; owns the input and output handshakes; depends on skf_pkg
`include "scalar_kalman_filter_defines.svh"

module skf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output skf_pkg::dp_cmd_t cmd
);
    import skf_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             room;

    // result register free, or being emptied this cycle
    assign room = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_PRED;
            ST_PRED:    state_next = ST_DIV;
            ST_DIV:     if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_MUL_EST;
            ST_MUL_EST: state_next = ST_MUL_ERR;
            ST_MUL_ERR: state_next = ST_DONE;
            ST_DONE:    if (room) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_PRED:    cmd.pred = 1'b1;
            ST_DIV:
            begin
                cmd.div_first = (cnt_reg == '0);
                cmd.div_step  = (cnt_reg != '0);
            end
            ST_MUL_EST: cmd.mul_est = 1'b1;
            ST_MUL_ERR: cmd.mul_err = 1'b1;
            ST_DONE:    cmd.commit  = room;
            default:    cmd = '0;
        endcase
    end

    // divider step counter
    always_comb
    begin
        cnt_next = '0;
        if (state_reg == ST_DIV)
            cnt_next = cnt_reg + 1'b1;
    end

    // result valid flag
    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    `SKF_ASSERT_NXT(a_accept_pred, clk, rst_n, in_valid && in_ready, state_reg == ST_PRED)
    `SKF_ASSERT_IMP(a_commit_room, clk, rst_n, cmd.commit, !out_valid_reg || out_ready)
    `SKF_ASSERT_NXT(a_commit_valid, clk, rst_n, cmd.commit, out_valid_reg)
    `SKF_ASSERT_IMP(a_div_count, clk, rst_n, state_reg == ST_DIV, cnt_reg < CNT_W'(DIV_STEPS))
    `SKF_ASSERT_ALWAYS(a_cmd_single, clk, rst_n, $onehot0({cmd.load_in, cmd.pred, cmd.div_first, cmd.div_step, cmd.mul_est, cmd.mul_err, cmd.commit}))

endmodule

// ===== sv/scalar_kalman_filter.sv =====
// scalar random-walk kalman filter in q16.16, top level
// instantiates skf_ctrl and skf_dp; depends on skf_pkg
//
// usage:
//   in channel (in_valid/in_ready, measurement) takes one measurement item.
//   out channel (out_valid/out_ready) returns new_estimate, new_error, gain.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the four
//   registers: process variance, measurement variance, initial estimate,
//   initial error. cfg_ready is always high; write only while idle.
//   writing an initial register reloads estimate and error from both.
//   sequence: an accepted item goes through predict, 17 steps of the
//   bit-serial gain divider, two passes of the shared multiplier and
//   commit. a new item is accepted only while the controller is idle,
//   after the previous item has been committed.
//   a finished result waits in the output register; the next item is
//   accepted and worked on meanwhile, and only its commit waits for the
//   output register to empty.
//   reset: registers take their default values, state is loaded from the
//   initial registers, no result is pending.
module scalar_kalman_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [skf_pkg::DATA_W-1:0] measurement,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [skf_pkg::DATA_W-1:0] new_estimate,
    output logic [skf_pkg::DATA_W-1:0]        new_error,
    output logic [skf_pkg::GAIN_W-1:0]        gain,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [skf_pkg::IDX_W-1:0]         cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]        cfg_data
);
    import skf_pkg::*;

    dp_cmd_t cmd;

    // sequencer
    skf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // arithmetic and state
    skf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .measurement  (measurement),
        .new_estimate (new_estimate),
        .new_error    (new_error),
        .gain         (gain)
    );

endmodule
